[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL; compiled away for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Plain property check, disabled while reset is asserted.
`define EABV_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("eabv: property check failed");
// Signed range check on a value when enable is high.
`define EABV_ASSERT_RANGE(lbl, clk, rst_n, en, sig, lim) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		(en) |-> (((sig) <= (lim)) && ((sig) >= -(lim)))) \
		else $error("eabv: value out of range");
`else
`define EABV_ASSERT(lbl, clk, rst_n, prop)
`define EABV_ASSERT_RANGE(lbl, clk, rst_n, en, sig, lim)
`endif

`endif

[hw/rtl/eabv_pkg.sv]
`default_nettype none

package eabv_pkg;

	// Defaults for the top-level parameters
	localparam int EABV_ANGLE_BITS = 16;
	localparam int EABV_FRAC_BITS  = 14;

	// Fixed port widths
	localparam int ANGLE_W = 16;
	localparam int OUT_W   = 16;

	// Polynomial datapath is unsigned Q30
	localparam int Q_BITS = 30;
	localparam logic [Q_BITS:0] Q_ONE = {1'b1, {Q_BITS{1'b0}}};

	// Taylor coefficients of sin(pi/2 * x), Q30
	localparam logic [Q_BITS:0] QS_C0 = 31'd1686629713;
	localparam logic [Q_BITS:0] QS_C1 = 31'd693598668;
	localparam logic [Q_BITS:0] QS_C2 = 31'd85569306;
	localparam logic [Q_BITS:0] QS_C3 = 31'd5026995;
	localparam logic [Q_BITS:0] QS_C4 = 31'd172272;

	// Pipeline depths
	localparam int QS_LAT    = 7;
	localparam int SC_LAT    = QS_LAT + 1;
	localparam int BASIS_LAT = 5;
	localparam int TOTAL_LAT = SC_LAT + BASIS_LAT;

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

endpackage

`default_nettype wire

[hw/rtl/euler_angles_to_basis_vectors_top.sv]
// Pitch/yaw/roll binary angles in, forward/right/up basis vectors out (Q1.FRAC_BITS).
// The done strobe follows the start transfer through the sine/cosine stages, then the
// product and sum stages.
// Throughput: one item per cycle; busy stays low, a new start is taken every cycle.
// Reset: arst_n clears only the valid pipeline; datapath registers are not reset.
`default_nettype none
`include "assert_macros.svh"

module euler_angles_to_basis_vectors_top import eabv_pkg::*; #(
	parameter int ANGLE_BITS = EABV_ANGLE_BITS,
	parameter int FRAC_BITS  = EABV_FRAC_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic        [ANGLE_W-1:0] pitch,
	input  wire logic        [ANGLE_W-1:0] yaw,
	input  wire logic        [ANGLE_W-1:0] roll,
	output logic                           done,
	output logic signed      [OUT_W-1:0]   fwd_x,
	output logic signed      [OUT_W-1:0]   fwd_y,
	output logic signed      [OUT_W-1:0]   fwd_z,
	output logic signed      [OUT_W-1:0]   rgt_x,
	output logic signed      [OUT_W-1:0]   rgt_y,
	output logic signed      [OUT_W-1:0]   rgt_z,
	output logic signed      [OUT_W-1:0]   upv_x,
	output logic signed      [OUT_W-1:0]   upv_y,
	output logic signed      [OUT_W-1:0]   upv_z
);

	localparam int SW = FRAC_BITS + 2;

	// The datapath is a free-running pipeline: nothing downstream can stall it,
	// so every cycle is open for a new transfer.
	logic accept;
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Valid bits riding alongside the sine/cosine stages.
	logic vld_s [1:SC_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= SC_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			vld_s[1] <= accept;
			for (int i = 2; i <= SC_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Three independent sine/cosine units, one per angle.
	logic signed [SW-1:0] sp, cp, sy, cy, sr, cr;

	eabv_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sc_pitch (
		.clk(clk), .angle(pitch), .sin_v(sp), .cos_v(cp)
	);
	eabv_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sc_yaw (
		.clk(clk), .angle(yaw), .sin_v(sy), .cos_v(cy)
	);
	eabv_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sc_roll (
		.clk(clk), .angle(roll), .sin_v(sr), .cos_v(cr)
	);

	// Products and saturating sums; its final register is the output register.
	logic                 basis_vld;
	logic signed [SW-1:0] bfx, bfy, bfz, brx, bry, brz, bux, buy, buz;

	eabv_basis #(.FRAC_BITS(FRAC_BITS)) u_basis (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s[SC_LAT]),
		.sp        (sp),
		.cp        (cp),
		.sy        (sy),
		.cy        (cy),
		.sr        (sr),
		.cr        (cr),
		.out_valid (basis_vld),
		.fwd_x     (bfx),
		.fwd_y     (bfy),
		.fwd_z     (bfz),
		.rgt_x     (brx),
		.rgt_y     (bry),
		.rgt_z     (brz),
		.upv_x     (bux),
		.upv_y     (buy),
		.upv_z     (buz)
	);

	// Pack to the 16-bit result fields (sign extend or wrap).
	assign done  = basis_vld;
	assign fwd_x = OUT_W'(bfx);
	assign fwd_y = OUT_W'(bfy);
	assign fwd_z = OUT_W'(bfz);
	assign rgt_x = OUT_W'(brx);
	assign rgt_y = OUT_W'(bry);
	assign rgt_z = OUT_W'(brz);
	assign upv_x = OUT_W'(bux);
	assign upv_y = OUT_W'(buy);
	assign upv_z = OUT_W'(buz);

	// Every transfer yields exactly one done strobe, and no strobe appears without one.
	`EABV_ASSERT(a_done_follows, clk, arst_n, accept |-> ##TOTAL_LAT done)
	`EABV_ASSERT(a_no_spurious, clk, arst_n, !accept |-> ##TOTAL_LAT !done)

endmodule

`default_nettype wire

[hw/rtl/eabv_qsine.sv]
`default_nettype none

// Quarter-wave sine, Horner form, at most one multiply per stage.
module eabv_qsine import eabv_pkg::*; #(
	parameter int FRAC_BITS = EABV_FRAC_BITS
) (
	input  wire logic                 clk,
	input  wire logic [Q_BITS:0]      x,
	output logic      [FRAC_BITS:0]   y
);

	localparam int PW = 2 * Q_BITS + 2;
	localparam logic [Q_BITS+1:0] ONE_R = (Q_BITS+2)'(1) << FRAC_BITS;

	function automatic logic [Q_BITS:0] hstep(logic [Q_BITS:0] c, logic [Q_BITS:0] p,
			logic [Q_BITS:0] x2);
		logic [PW-1:0] m;
		m = p * x2;
		return c - m[2*Q_BITS:Q_BITS];
	endfunction

	logic [Q_BITS:0] x_s1, x_s2, x_s3, x_s4, x_s5;
	logic [Q_BITS:0] x2_s1, x2_s2, x2_s3, x2_s4;
	logic [Q_BITS:0] p_s2, p_s3, p_s4, p_s5;
	logic [Q_BITS:0] s_s6;
	logic [FRAC_BITS:0] y_s7;

	logic [PW-1:0]     sq;
	logic [PW-1:0]     fin;
	logic [Q_BITS+1:0] rnd;

	assign sq  = x * x;
	assign fin = p_s5 * x_s5;

	generate
		if (FRAC_BITS < Q_BITS) begin : g_round
			localparam logic [Q_BITS+1:0] HALF = (Q_BITS+2)'(1) << (Q_BITS - FRAC_BITS - 1);
			assign rnd = ({1'b0, s_s6} + HALF) >> (Q_BITS - FRAC_BITS);
		end else begin : g_exact
			assign rnd = {1'b0, s_s6};
		end
	endgenerate

	always_ff @(posedge clk) begin
		x_s1  <= x;
		x2_s1 <= sq[2*Q_BITS:Q_BITS];

		x_s2  <= x_s1;
		x2_s2 <= x2_s1;
		p_s2  <= hstep(QS_C3, QS_C4, x2_s1);

		x_s3  <= x_s2;
		x2_s3 <= x2_s2;
		p_s3  <= hstep(QS_C2, p_s2, x2_s2);

		x_s4  <= x_s3;
		x2_s4 <= x2_s3;
		p_s4  <= hstep(QS_C1, p_s3, x2_s3);

		x_s5  <= x_s4;
		p_s5  <= hstep(QS_C0, p_s4, x2_s4);

		s_s6  <= fin[2*Q_BITS:Q_BITS];

		// round half up, clamp to 1.0
		y_s7  <= (rnd > ONE_R) ? ONE_R[FRAC_BITS:0] : rnd[FRAC_BITS:0];
	end

	assign y = y_s7;

endmodule

`default_nettype wire

[hw/rtl/eabv_sincos.sv]
`default_nettype none

// Sine and cosine of one binary angle via quadrant folding.
module eabv_sincos import eabv_pkg::*; #(
	parameter int ANGLE_BITS = EABV_ANGLE_BITS,
	parameter int FRAC_BITS  = EABV_FRAC_BITS
) (
	input  wire logic                        clk,
	input  wire logic        [ANGLE_W-1:0]   angle,
	output logic signed      [FRAC_BITS+1:0] sin_v,
	output logic signed      [FRAC_BITS+1:0] cos_v
);

	localparam int SW = FRAC_BITS + 2;

	logic [ANGLE_BITS-1:0] a;
	quad_t                 quad;
	logic [Q_BITS:0]       xa, xb;
	logic [FRAC_BITS:0]    sx, sc;
	logic signed [SW-1:0]  px, pc;

	quad_t quad_s [1:QS_LAT];
	logic signed [SW-1:0] sin_s8, cos_s8;

	generate
		if (ANGLE_BITS <= ANGLE_W) begin : g_trunc
			assign a = angle[ANGLE_BITS-1:0];
		end else begin : g_ext
			assign a = {{(ANGLE_BITS-ANGLE_W){1'b0}}, angle};
		end
	endgenerate

	assign quad = quad_t'(a[ANGLE_BITS-1 -: 2]);
	assign xa   = {1'b0, a[ANGLE_BITS-3:0], {(Q_BITS+2-ANGLE_BITS){1'b0}}};
	assign xb   = Q_ONE - xa;

	eabv_qsine #(.FRAC_BITS(FRAC_BITS)) u_qs_x (.clk(clk), .x(xa), .y(sx));
	eabv_qsine #(.FRAC_BITS(FRAC_BITS)) u_qs_c (.clk(clk), .x(xb), .y(sc));

	assign px = signed'({1'b0, sx});
	assign pc = signed'({1'b0, sc});

	always_ff @(posedge clk) begin
		quad_s[1] <= quad;
		for (int i = 2; i <= QS_LAT; i++) begin
			quad_s[i] <= quad_s[i-1];
		end
		case (quad_s[QS_LAT])
			QUAD_0: begin
				sin_s8 <= px;
				cos_s8 <= pc;
			end
			QUAD_1: begin
				sin_s8 <= pc;
				cos_s8 <= -px;
			end
			QUAD_2: begin
				sin_s8 <= -px;
				cos_s8 <= -pc;
			end
			QUAD_3: begin
				sin_s8 <= -pc;
				cos_s8 <= px;
			end
		endcase
	end

	assign sin_v = sin_s8;
	assign cos_v = cos_s8;

endmodule

`default_nettype wire

[hw/rtl/eabv_basis.sv]
`default_nettype none
`include "assert_macros.svh"

// Products and sums forming the three basis vectors.
module eabv_basis import eabv_pkg::*; #(
	parameter int FRAC_BITS = EABV_FRAC_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic signed [FRAC_BITS+1:0] sp,
	input  wire logic signed [FRAC_BITS+1:0] cp,
	input  wire logic signed [FRAC_BITS+1:0] sy,
	input  wire logic signed [FRAC_BITS+1:0] cy,
	input  wire logic signed [FRAC_BITS+1:0] sr,
	input  wire logic signed [FRAC_BITS+1:0] cr,
	output logic                             out_valid,
	output logic signed      [FRAC_BITS+1:0] fwd_x,
	output logic signed      [FRAC_BITS+1:0] fwd_y,
	output logic signed      [FRAC_BITS+1:0] fwd_z,
	output logic signed      [FRAC_BITS+1:0] rgt_x,
	output logic signed      [FRAC_BITS+1:0] rgt_y,
	output logic signed      [FRAC_BITS+1:0] rgt_z,
	output logic signed      [FRAC_BITS+1:0] upv_x,
	output logic signed      [FRAC_BITS+1:0] upv_y,
	output logic signed      [FRAC_BITS+1:0] upv_z
);

	localparam int SW = FRAC_BITS + 2;
	localparam int MW = FRAC_BITS + 1;
	localparam int PW = 2 * MW;

	localparam logic [PW-1:0]        HALF  = PW'(1) << (FRAC_BITS - 1);
	localparam logic signed [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;
	localparam logic signed [SW:0]   ONE_W = (SW+1)'(1) << FRAC_BITS;

	// first-level products
	localparam int P_CPCY = 0;
	localparam int P_CPSY = 1;
	localparam int P_CRSY = 2;
	localparam int P_CRCY = 3;
	localparam int P_SRCP = 4;
	localparam int P_SRSY = 5;
	localparam int P_SRCY = 6;
	localparam int P_CRCP = 7;
	localparam int P_SRSP = 8;
	localparam int P_CRSP = 9;
	localparam int NP1    = 10;

	// second-level products (t1 = sr*sp, t2 = cr*sp)
	localparam int Q_T1CY = 0;
	localparam int Q_T1SY = 1;
	localparam int Q_T2CY = 2;
	localparam int Q_T2SY = 3;
	localparam int NP2    = 4;

	function automatic logic [MW-1:0] mag(logic signed [SW-1:0] v);
		logic signed [SW-1:0] n;
		n = -v;
		return v[SW-1] ? n[MW-1:0] : v[MW-1:0];
	endfunction

	// round half away from zero, then apply sign
	function automatic logic signed [SW-1:0] rnd(logic [PW-1:0] m, logic neg);
		logic [PW-1:0]        r;
		logic signed [SW-1:0] v;
		r = (m + HALF) >> FRAC_BITS;
		v = signed'({1'b0, r[MW-1:0]});
		return neg ? -v : v;
	endfunction

	function automatic logic signed [SW-1:0] clamp1(logic signed [SW:0] v);
		logic signed [SW-1:0] r;
		if (v > ONE_W) begin
			r = ONE_S;
		end else if (v < -ONE_W) begin
			r = -ONE_S;
		end else begin
			r = v[SW-1:0];
		end
		return r;
	endfunction

	logic signed [SW-1:0] opa [NP1];
	logic signed [SW-1:0] opb [NP1];
	logic signed [SW-1:0] opc [NP2];
	logic signed [SW-1:0] opd [NP2];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic [PW-1:0]        prod_s1 [NP1];
	logic                 neg_s1  [NP1];
	logic signed [SW-1:0] sp_s1, cy_s1, sy_s1;

	logic signed [SW-1:0] val_s2 [NP1];
	logic signed [SW-1:0] sp_s2, cy_s2, sy_s2;

	logic [PW-1:0]        prod_s3 [NP2];
	logic                 neg_s3  [NP2];
	logic signed [SW-1:0] val_s3 [NP1];
	logic signed [SW-1:0] sp_s3;

	logic signed [SW-1:0] val2_s4 [NP2];
	logic signed [SW-1:0] val_s4 [NP1];
	logic signed [SW-1:0] sp_s4;

	logic signed [SW-1:0] fwd_x_s5, fwd_y_s5, fwd_z_s5;
	logic signed [SW-1:0] rgt_x_s5, rgt_y_s5, rgt_z_s5;
	logic signed [SW-1:0] upv_x_s5, upv_y_s5, upv_z_s5;

	always_comb begin
		opa[P_CPCY] = cp; opb[P_CPCY] = cy;
		opa[P_CPSY] = cp; opb[P_CPSY] = sy;
		opa[P_CRSY] = cr; opb[P_CRSY] = sy;
		opa[P_CRCY] = cr; opb[P_CRCY] = cy;
		opa[P_SRCP] = sr; opb[P_SRCP] = cp;
		opa[P_SRSY] = sr; opb[P_SRSY] = sy;
		opa[P_SRCY] = sr; opb[P_SRCY] = cy;
		opa[P_CRCP] = cr; opb[P_CRCP] = cp;
		opa[P_SRSP] = sr; opb[P_SRSP] = sp;
		opa[P_CRSP] = cr; opb[P_CRSP] = sp;

		opc[Q_T1CY] = val_s2[P_SRSP]; opd[Q_T1CY] = cy_s2;
		opc[Q_T1SY] = val_s2[P_SRSP]; opd[Q_T1SY] = sy_s2;
		opc[Q_T2CY] = val_s2[P_CRSP]; opd[Q_T2CY] = cy_s2;
		opc[Q_T2SY] = val_s2[P_CRSP]; opd[Q_T2SY] = sy_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		// s1: magnitude products
		for (int i = 0; i < NP1; i++) begin
			prod_s1[i] <= mag(opa[i]) * mag(opb[i]);
			neg_s1[i]  <= opa[i][SW-1] ^ opb[i][SW-1];
		end
		sp_s1 <= sp;
		cy_s1 <= cy;
		sy_s1 <= sy;

		// s2: round and sign
		for (int i = 0; i < NP1; i++) begin
			val_s2[i] <= rnd(prod_s1[i], neg_s1[i]);
		end
		sp_s2 <= sp_s1;
		cy_s2 <= cy_s1;
		sy_s2 <= sy_s1;

		// s3: triple products
		for (int i = 0; i < NP2; i++) begin
			prod_s3[i] <= mag(opc[i]) * mag(opd[i]);
			neg_s3[i]  <= opc[i][SW-1] ^ opd[i][SW-1];
		end
		val_s3 <= val_s2;
		sp_s3  <= sp_s2;

		// s4: round and sign
		for (int i = 0; i < NP2; i++) begin
			val2_s4[i] <= rnd(prod_s3[i], neg_s3[i]);
		end
		val_s4 <= val_s3;
		sp_s4  <= sp_s3;

		// s5: sums with saturation; single terms pass through or are negated
		fwd_x_s5 <= val_s4[P_CPCY];
		fwd_y_s5 <= val_s4[P_CPSY];
		fwd_z_s5 <= -sp_s4;
		rgt_x_s5 <= clamp1((SW+1)'(val_s4[P_CRSY]) - (SW+1)'(val2_s4[Q_T1CY]));
		rgt_y_s5 <= clamp1(-(SW+1)'(val2_s4[Q_T1SY]) - (SW+1)'(val_s4[P_CRCY]));
		rgt_z_s5 <= -val_s4[P_SRCP];
		upv_x_s5 <= clamp1((SW+1)'(val2_s4[Q_T2CY]) + (SW+1)'(val_s4[P_SRSY]));
		upv_y_s5 <= clamp1((SW+1)'(val2_s4[Q_T2SY]) - (SW+1)'(val_s4[P_SRCY]));
		upv_z_s5 <= val_s4[P_CRCP];
	end

	assign out_valid = vld_s5;
	assign fwd_x     = fwd_x_s5;
	assign fwd_y     = fwd_y_s5;
	assign fwd_z     = fwd_z_s5;
	assign rgt_x     = rgt_x_s5;
	assign rgt_y     = rgt_y_s5;
	assign rgt_z     = rgt_z_s5;
	assign upv_x     = upv_x_s5;
	assign upv_y     = upv_y_s5;
	assign upv_z     = upv_z_s5;

	`EABV_ASSERT_RANGE(a_rgt_x_sat, clk, arst_n, vld_s5, rgt_x_s5, ONE_S)
	`EABV_ASSERT_RANGE(a_upv_y_sat, clk, arst_n, vld_s5, upv_y_s5, ONE_S)

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import eabv_pkg::*;

	// Build of the block under test and derived fixed-point constants
	localparam int ANGLE_BITS = EABV_ANGLE_BITS;
	localparam int FRAC_BITS  = EABV_FRAC_BITS;
	localparam longint FX_ONE = longint'(1) << FRAC_BITS;
	localparam int CLK_HALF   = 5;
	localparam int N_RANDOM   = 700;
	localparam int MAX_SHOWN  = 40;

	// One input transfer: three binary angles
	typedef struct packed {
		logic [ANGLE_W-1:0] pitch;
		logic [ANGLE_W-1:0] yaw;
		logic [ANGLE_W-1:0] roll;
	} euler_t;

	// One result: fwd x/y/z, rgt x/y/z, upv x/y/z, left to right
	typedef logic [0:8][OUT_W-1:0] basis_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [ANGLE_W-1:0] pitch = '0;
	logic [ANGLE_W-1:0] yaw = '0;
	logic [ANGLE_W-1:0] roll = '0;
	logic busy;
	logic done;
	logic signed [OUT_W-1:0] fwd_x, fwd_y, fwd_z;
	logic signed [OUT_W-1:0] rgt_x, rgt_y, rgt_z;
	logic signed [OUT_W-1:0] upv_x, upv_y, upv_z;

	euler_t angle_q[$];      // angle triples still to be sent
	basis_t basis_q[$];      // predicted basis vectors, oldest first
	int err_cnt = 0;
	int result_cnt = 0;
	int burst_left = 0;
	int gap_left = 0;
	string field_name [9] = '{"fwd_x", "fwd_y", "fwd_z", "rgt_x", "rgt_y", "rgt_z",
		"upv_x", "upv_y", "upv_z"};

	euler_angles_to_basis_vectors_top #(
		.ANGLE_BITS(ANGLE_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.pitch (pitch),
		.yaw   (yaw),
		.roll  (roll),
		.done  (done),
		.fwd_x (fwd_x),
		.fwd_y (fwd_y),
		.fwd_z (fwd_z),
		.rgt_x (rgt_x),
		.rgt_y (rgt_y),
		.rgt_z (rgt_z),
		.upv_x (upv_x),
		.upv_y (upv_y),
		.upv_z (upv_z)
	);

	always #CLK_HALF clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Odd polynomial for sin(pi/2 * x), x in unsigned Q30 over [0, 1].
	// Every product truncates; the result rounds half up to FRAC_BITS
	// and is clamped at 1.0.
	function automatic longint quarter_sine(input logic [63:0] x);
		logic [63:0] x2, p, s;
		x2 = (x * x) >> Q_BITS;
		p = 64'(QS_C4);
		p = 64'(QS_C3) - ((p * x2) >> Q_BITS);
		p = 64'(QS_C2) - ((p * x2) >> Q_BITS);
		p = 64'(QS_C1) - ((p * x2) >> Q_BITS);
		p = 64'(QS_C0) - ((p * x2) >> Q_BITS);
		s = (p * x) >> Q_BITS;
		if (Q_BITS > FRAC_BITS)
			s = (s + (64'd1 << (Q_BITS - FRAC_BITS - 1))) >> (Q_BITS - FRAC_BITS);
		if (s > 64'(FX_ONE))
			s = 64'(FX_ONE);
		return longint'(s);
	endfunction

	// Quadrant folding: top two angle bits pick the quadrant, the rest
	// becomes a Q30 fraction of a quarter turn. Bits above ANGLE_BITS drop.
	function automatic void angle_sin_cos(input logic [ANGLE_W-1:0] ang,
			output longint s, output longint c);
		logic [63:0] a, x;
		quad_t q;
		longint sx, sc;
		a = 64'(ang) & ((64'd1 << ANGLE_BITS) - 1);
		q = quad_t'(a[ANGLE_BITS-1 -: 2]);
		x = (a & ((64'd1 << (ANGLE_BITS - 2)) - 1)) << (32 - ANGLE_BITS);
		sx = quarter_sine(x);
		sc = quarter_sine(64'(Q_ONE) - x);
		case (q)
			QUAD_0: begin s = sx; c = sc; end
			QUAD_1: begin s = sc; c = -sx; end
			QUAD_2: begin s = -sx; c = -sc; end
			default: begin s = -sc; c = sx; end
		endcase
	endfunction

	function automatic longint clamp_unit(input longint v);
		if (v > FX_ONE)
			return FX_ONE;
		if (v < -FX_ONE)
			return -FX_ONE;
		return v;
	endfunction

	// Sign-magnitude product, rounded half away from zero, then clamped
	function automatic longint fx_mul(input longint a, input longint b);
		logic neg;
		logic [63:0] ma, mb, m;
		neg = (a < 0) != (b < 0);
		ma = 64'(a < 0 ? -a : a);
		mb = 64'(b < 0 ? -b : b);
		m = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return clamp_unit(neg ? -longint'(m) : longint'(m));
	endfunction

	function automatic basis_t predict_basis(input euler_t e);
		longint sp, cp, sy, cy, sr, cr, t_sp, t_cp;
		basis_t b;
		angle_sin_cos(e.pitch, sp, cp);
		angle_sin_cos(e.yaw, sy, cy);
		angle_sin_cos(e.roll, sr, cr);
		t_sp = fx_mul(sr, sp);
		t_cp = fx_mul(cr, sp);
		b[0] = OUT_W'(fx_mul(cp, cy));
		b[1] = OUT_W'(fx_mul(cp, sy));
		b[2] = OUT_W'(-sp);
		b[3] = OUT_W'(clamp_unit(fx_mul(cr, sy) - fx_mul(t_sp, cy)));
		b[4] = OUT_W'(clamp_unit(-fx_mul(t_sp, sy) - fx_mul(cr, cy)));
		b[5] = OUT_W'(-fx_mul(sr, cp));
		b[6] = OUT_W'(clamp_unit(fx_mul(t_cp, cy) + fx_mul(sr, sy)));
		b[7] = OUT_W'(clamp_unit(fx_mul(t_cp, sy) - fx_mul(sr, cy)));
		b[8] = OUT_W'(fx_mul(cr, cp));
		return b;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Angle picker: mostly uniform, the rest hugging quadrant edges
	// (where the fold switches) and the 45-degree points (where the
	// right/up sums come closest to saturating).
	function automatic logic [ANGLE_W-1:0] pick_angle();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return ANGLE_W'($urandom);
		if (sel < 8)
			return ANGLE_W'(($urandom_range(0, 3) << (ANGLE_BITS - 2))
				+ $urandom_range(0, 8) - 4);
		return ANGLE_W'(($urandom_range(0, 7) << (ANGLE_BITS - 3))
			+ $urandom_range(0, 64) - 32);
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_cnt < MAX_SHOWN)
			$display("%0t ns MISMATCH: %s", $time, msg);
		err_cnt++;
	endtask

	// ------------------------------------------------------------------
	// Driver: takes angle triples from angle_q in bursts with random gaps.
	// A transfer happens at an edge where start is high and busy is low;
	// the prediction is made right there from the held payload.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive
		logic nxt_start;
		euler_t nxt_item;
		if (arst_n) begin
			nxt_start = start;
			nxt_item = '{pitch: pitch, yaw: yaw, roll: roll};
			if (start && !busy) begin
				basis_q.push_back(predict_basis(nxt_item));
				nxt_start = 1'b0;
			end
			// keep start high back to back inside a burst; only one
			// nonblocking update per signal per edge
			if (!nxt_start) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (angle_q.size() > 0) begin
					nxt_item = angle_q.pop_front();
					nxt_start = 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
			start <= nxt_start;
			pitch <= nxt_item.pitch;
			yaw <= nxt_item.yaw;
			roll <= nxt_item.roll;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: done marks a one-cycle result; nothing can hold it off,
	// so every strobe is checked against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch
		basis_t got, want;
		if (arst_n && done) begin
			got = {fwd_x, fwd_y, fwd_z, rgt_x, rgt_y, rgt_z, upv_x, upv_y, upv_z};
			if (basis_q.size() == 0) begin
				report_mismatch("result with no transfer outstanding");
			end else begin
				want = basis_q.pop_front();
				for (int i = 0; i < 9; i++)
					if (got[i] !== want[i])
						report_mismatch($sformatf("result %0d %s got %0d expected %0d",
							result_cnt, field_name[i], $signed(got[i]),
							$signed(want[i])));
			end
			result_cnt++;
		end
	end

	// Reset once, released on a rising edge
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Test sequence: directed corners, then random triples; then drain.
	// ------------------------------------------------------------------
	initial begin : sequencer
		logic [ANGLE_W-1:0] corner [8];
		corner = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
			16'h3FFF, 16'h7FFF, 16'h2000};

		// level angles, all-ones, and each angle alone at the other six corners
		angle_q.push_back('{pitch: 16'h0000, yaw: 16'h0000, roll: 16'h0000});
		angle_q.push_back('{pitch: 16'hFFFF, yaw: 16'hFFFF, roll: 16'hFFFF});
		for (int i = 2; i < 8; i++) begin
			angle_q.push_back('{pitch: corner[i], yaw: 16'h0000, roll: 16'h0000});
			angle_q.push_back('{pitch: 16'h0000, yaw: corner[i], roll: 16'h0000});
			angle_q.push_back('{pitch: 16'h0000, yaw: 16'h0000, roll: corner[i]});
		end
		// 45-degree points in every quadrant, where the sums press on 1.0, then one triple just off quadrant edges
		angle_q.push_back('{pitch: 16'h2000, yaw: 16'h2000, roll: 16'h2000});
		angle_q.push_back('{pitch: 16'h6000, yaw: 16'hA000, roll: 16'hE000});
		angle_q.push_back('{pitch: 16'hE000, yaw: 16'h6000, roll: 16'hA000});
		angle_q.push_back('{pitch: 16'hC001, yaw: 16'hBFFF, roll: 16'h4001});

		for (int n = 0; n < N_RANDOM; n++)
			angle_q.push_back('{pitch: pick_angle(), yaw: pick_angle(),
				roll: pick_angle()});

		// everything sent, every prediction matched by a strobe
		do @(posedge clk);
		while (angle_q.size() != 0 || start || basis_q.size() != 0);

		// then keep watching for stray strobes
		repeat (TOTAL_LAT + 8) @(posedge clk);

		if (err_cnt == 0 && basis_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Hang guard: ~730 transfers with gaps finish well before this timeout
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/eabv_pkg.sv
hw/rtl/eabv_qsine.sv
hw/rtl/eabv_sincos.sv
hw/rtl/eabv_basis.sv
hw/rtl/euler_angles_to_basis_vectors_top.sv
tb/sv/tb_top.sv
